// ----- design/csd_pkg.sv -----
// Package for the C-SCAN disk request ordering block.
// Holds the field widths, register indexes and shared control types.
// No dependencies; every other design file except csd_ram imports it.
package csd_pkg;

   localparam int CSD_MAX_REQUESTS = 64;

   localparam int CYL_W      = 16;
   localparam int POS_W      = 6;
   localparam int TRAVEL_W   = 18;
   localparam int ACC_W      = TRAVEL_W + 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_START_POSITION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISK_CYLINDERS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP_UP       = 2'd2;

   localparam logic [CYL_W-1:0]      START_RESET     = 16'd0;
   localparam logic [CSR_DATA_W-1:0] CYLINDERS_RESET = 17'h10000;
   localparam logic                  SWEEP_UP_RESET  = 1'b1;

   // Operation of the travel accumulator.
   typedef enum logic [2:0] {
      TRV_HOLD,
      TRV_CLEAR,
      TRV_MOVE,
      TRV_RUN,
      TRV_JUMP
   } trv_op_type;

   // Controls for the minimum search unit.
   typedef struct packed {
      logic clear;
      logic cand_valid;
   } sel_ctrl_type;

endpackage

// ----- design/csd_req_if.sv -----
// Request channel of the C-SCAN ordering block: valid, ready and one request.
// Depends on csd_pkg for the field widths.
interface csd_req_if import csd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CYL_W-1:0] request_cylinder;
   logic             last_request;

   modport source (output valid, output request_cylinder, output last_request, input ready);
   modport sink   (input valid, input request_cylinder, input last_request, output ready);
endinterface

// ----- design/csd_rsp_if.sv -----
// Result channel of the C-SCAN ordering block: valid, ready and one served request.
// Depends on csd_pkg for the field widths.
interface csd_rsp_if import csd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CYL_W-1:0]    served_cylinder;
   logic [POS_W-1:0]    order_position;
   logic                last_result;
   logic [TRAVEL_W-1:0] total_travel;
   logic                overflowed;

   modport source (output valid, output served_cylinder, output order_position,
                   output last_result, output total_travel, output overflowed, input ready);
   modport sink   (input valid, input served_cylinder, input order_position,
                   input last_result, input total_travel, input overflowed, output ready);
endinterface

// ----- design/csd_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module csd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/csd_select.sv -----
// Running minimum search: keeps the smallest candidate key strictly above a floor.
// Depends on csd_pkg for the control struct.
module csd_select import csd_pkg::*; #(
   parameter int COMP_W = 23
) (
   input  logic              clock,
   input  logic              reset,
   input  sel_ctrl_type      ctrl,
   input  logic [COMP_W-1:0] cand,
   input  logic [COMP_W-1:0] floor_key,
   input  logic              floor_valid,
   output logic [COMP_W-1:0] best
);

   logic [COMP_W-1:0] best_ff, best_in;
   logic              best_valid_ff, best_valid_in;
   logic              above, better;

   always_comb begin
      above         = !floor_valid || (cand > floor_key);
      better        = !best_valid_ff || (cand < best_ff);
      best_in       = best_ff;
      best_valid_in = best_valid_ff;
      if (ctrl.clear) begin
         best_valid_in = 1'b0;
      end else if (ctrl.cand_valid && above && better) begin
         best_in       = cand;
         best_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_valid_ff <= 1'b0;
      end else begin
         best_valid_ff <= best_valid_in;
      end
      best_ff <= best_in;
   end

   assign best = best_ff;

endmodule

// ----- design/csd_travel.sv -----
// Head travel accumulator: one absolute-difference unit feeding one adder.
// Depends on csd_pkg for widths and the operation type.
module csd_travel import csd_pkg::*; (
   input  logic                clock,
   input  trv_op_type          op,
   input  logic [CYL_W-1:0]    start,
   input  logic [CYL_W-1:0]    high,
   input  logic                sweep_up,
   input  logic [CYL_W-1:0]    target,
   output logic [TRAVEL_W-1:0] travel
);

   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [CYL_W-1:0] pos_ff, pos_in;
   logic [CYL_W-1:0] opa, opb, diff;

   always_comb begin
      // The jump back over the whole disk is a distance from cylinder zero.
      opa = (op == TRV_JUMP) ? '0 : pos_ff;
      case (op)
         TRV_MOVE: opb = target;
         TRV_RUN:  opb = sweep_up ? high : '0;
         default:  opb = high;
      endcase
      diff = (opa > opb) ? (opa - opb) : (opb - opa);

      acc_in = acc_ff;
      pos_in = pos_ff;
      case (op)
         TRV_CLEAR: begin
            acc_in = '0;
            pos_in = start;
         end
         TRV_MOVE: begin
            acc_in = acc_ff + ACC_W'(diff);
            pos_in = target;
         end
         TRV_RUN: begin
            acc_in = acc_ff + ACC_W'(diff);
         end
         TRV_JUMP: begin
            acc_in = acc_ff + ACC_W'(diff);
            pos_in = sweep_up ? '0 : high;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      pos_ff <= pos_in;
   end

   assign travel = acc_ff[ACC_W-1] ? {TRAVEL_W{1'b1}} : acc_ff[TRAVEL_W-1:0];

endmodule

// ----- design/cscan_disk_request_order.sv -----
// C-SCAN disk request ordering, top level.
// Requests arrive as beats on req_ch, one cylinder per beat, and are written into
// a request RAM of MAX_REQUESTS entries. Requests beyond capacity are dropped
// and remembered as an overflow. The beat marked last_request closes the batch:
// req_ch.ready drops and the block emits one rsp_ch beat per stored request in
// C-SCAN service order. The final beat carries the total head travel, including
// the run to the disk end and the return jump. Each result is found by one pass
// of a shared minimum search over the RAM (one read per cycle), followed by the
// pick state, the move state and the output state. The one result that takes the
// run to the disk end and the return jump also passes through the run and jump
// states. The search for the next result starts only after the current result
// is accepted, and the block takes no new requests until the batch is drained.
// If the receiver stalls, the current result stays on rsp_ch unchanged and
// the search waits. Configuration (start_position, disk_cylinders, sweep_up)
// is to be written on the csr_ port between batches; the block does not enforce
// this. A synchronous reset empties the store, clears the overflow mark,
// restores the register defaults and returns the block to loading; the RAM
// contents are not cleared.
// Depends on csd_pkg, csd_req_if, csd_rsp_if, csd_ram, csd_select, csd_travel.
module cscan_disk_request_order import csd_pkg::*; #(
   parameter int MAX_REQUESTS = CSD_MAX_REQUESTS
) (
   input  logic                  clock,
   input  logic                  reset,
   csd_req_if.sink               req_ch,
   csd_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W  = $clog2(MAX_REQUESTS);
   localparam int CNT_W  = $clog2(MAX_REQUESTS + 1);
   localparam int COMP_W = 1 + CYL_W + IDX_W;

   typedef enum logic [6:0] {
      ST_LOAD      = 7'b0000001,
      ST_SCAN      = 7'b0000010,
      ST_PICK      = 7'b0000100,
      ST_WRAP_RUN  = 7'b0001000,
      ST_WRAP_JUMP = 7'b0010000,
      ST_MOVE      = 7'b0100000,
      ST_OUT       = 7'b1000000
   } state_type;

   // Configuration registers.
   logic [CYL_W-1:0]      start_ff;
   logic [CSR_DATA_W-1:0] cyl_ff;
   logic                  up_ff;
   logic [CYL_W-1:0]      high;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= START_RESET;
         cyl_ff   <= CYLINDERS_RESET;
         up_ff    <= SWEEP_UP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_POSITION: start_ff <= csr_wdata[CYL_W-1:0];
            CSR_DISK_CYLINDERS: cyl_ff   <= csr_wdata;
            CSR_SWEEP_UP:       up_ff    <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Highest cylinder, saturated into the 16-bit range; an empty disk gives zero.
   always_comb begin
      if (cyl_ff == '0) begin
         high = '0;
      end else if (cyl_ff[CSR_DATA_W-1]) begin
         high = {CYL_W{1'b1}};
      end else begin
         high = CYL_W'(cyl_ff - CSR_DATA_W'(1));
      end
   end

   // Sequencer state.
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic              d_valid_ff, d_valid_in;
   logic              d_last_ff, d_last_in;
   logic [IDX_W-1:0]  d_idx_ff, d_idx_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [COMP_W-1:0] prev_ff, prev_in;
   logic              prev_valid_ff, prev_valid_in;
   logic              wrapped_ff, wrapped_in;
   logic              moved_ff, moved_in;

   logic              req_fire, rsp_fire, has_room, issue, final_result;
   logic [CYL_W-1:0]  ram_rdata;
   logic              at_or_below;
   logic [COMP_W-1:0] cand, best;
   logic [CYL_W-1:0]  best_key, cur_cyl;
   logic              best_second;
   sel_ctrl_type      sel_ctrl;
   trv_op_type        trv_op;
   logic [TRAVEL_W-1:0] travel;

   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_fire     = rsp_ch.valid && rsp_ch.ready;
   assign has_room     = count_ff < CNT_W'(MAX_REQUESTS);
   assign issue        = rd_cnt_ff < n_ff;
   assign final_result = k_ff == (n_ff - CNT_W'(1));

   // Sort key: group bit first (zero for the group served before the wrap), then
   // the cylinder, inverted when sweeping down, then the RAM index so that equal
   // cylinders still get distinct keys and each entry is taken exactly once.
   assign at_or_below = ram_rdata <= start_ff;
   assign cand = {(up_ff ? at_or_below : !at_or_below),
                  (up_ff ? ram_rdata : ~ram_rdata), d_idx_ff};

   assign best_second = best[COMP_W-1];
   assign best_key    = best[COMP_W-2 -: CYL_W];
   assign cur_cyl     = up_ff ? best_key : ~best_key;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      n_in          = n_ff;
      rd_cnt_in     = rd_cnt_ff;
      d_valid_in    = 1'b0;
      d_last_in     = 1'b0;
      d_idx_in      = rd_cnt_ff[IDX_W-1:0];
      k_in          = k_ff;
      prev_in       = prev_ff;
      prev_valid_in = prev_valid_ff;
      wrapped_in    = wrapped_ff;
      moved_in      = moved_ff;
      sel_ctrl      = '{clear: 1'b0, cand_valid: 1'b0};
      trv_op        = TRV_HOLD;

      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (has_room) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_ch.last_request) begin
                  n_in          = has_room ? (count_ff + CNT_W'(1)) : count_ff;
                  rd_cnt_in     = '0;
                  k_in          = '0;
                  prev_valid_in = 1'b0;
                  wrapped_in    = 1'b0;
                  sel_ctrl.clear = 1'b1;
                  trv_op        = TRV_CLEAR;
                  state_in      = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // Reads go out one per cycle; data is compared in the next cycle.
            if (issue) begin
               rd_cnt_in  = rd_cnt_ff + CNT_W'(1);
               d_valid_in = 1'b1;
               d_last_in  = rd_cnt_ff == (n_ff - CNT_W'(1));
            end
            sel_ctrl.cand_valid = d_valid_ff;
            if (d_last_ff) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            moved_in = 1'b0;
            state_in = (best_second && !wrapped_ff) ? ST_WRAP_RUN : ST_MOVE;
         end
         ST_WRAP_RUN: begin
            trv_op   = TRV_RUN;
            state_in = ST_WRAP_JUMP;
         end
         ST_WRAP_JUMP: begin
            trv_op     = TRV_JUMP;
            wrapped_in = 1'b1;
            state_in   = moved_ff ? ST_OUT : ST_MOVE;
         end
         ST_MOVE: begin
            trv_op   = TRV_MOVE;
            moved_in = 1'b1;
            // The run to the end and the jump are counted even if nothing follows.
            state_in = (final_result && !wrapped_ff) ? ST_WRAP_RUN : ST_OUT;
         end
         ST_OUT: begin
            if (rsp_fire) begin
               if (final_result) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  k_in           = k_ff + CNT_W'(1);
                  prev_in        = best;
                  prev_valid_in  = 1'b1;
                  rd_cnt_in      = '0;
                  sel_ctrl.clear = 1'b1;
                  state_in       = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         n_ff          <= '0;
         rd_cnt_ff     <= '0;
         d_valid_ff    <= 1'b0;
         d_last_ff     <= 1'b0;
         k_ff          <= '0;
         prev_valid_ff <= 1'b0;
         wrapped_ff    <= 1'b0;
         moved_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         n_ff          <= n_in;
         rd_cnt_ff     <= rd_cnt_in;
         d_valid_ff    <= d_valid_in;
         d_last_ff     <= d_last_in;
         k_ff          <= k_in;
         prev_valid_ff <= prev_valid_in;
         wrapped_ff    <= wrapped_in;
         moved_ff      <= moved_in;
      end
      d_idx_ff <= d_idx_in;
      prev_ff  <= prev_in;
   end

   csd_ram #(
      .WIDTH (CYL_W),
      .DEPTH (MAX_REQUESTS)
   ) u_store (
      .clock (clock),
      .we    (req_fire && has_room),
      .waddr (count_ff[IDX_W-1:0]),
      .wdata (req_ch.request_cylinder),
      .raddr (rd_cnt_ff[IDX_W-1:0]),
      .rdata (ram_rdata)
   );

   csd_select #(
      .COMP_W (COMP_W)
   ) u_select (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (sel_ctrl),
      .cand        (cand),
      .floor_key   (prev_ff),
      .floor_valid (prev_valid_ff),
      .best        (best)
   );

   csd_travel u_travel (
      .clock    (clock),
      .op       (trv_op),
      .start    (start_ff),
      .high     (high),
      .sweep_up (up_ff),
      .target   (cur_cyl),
      .travel   (travel)
   );

   assign req_ch.ready           = state_ff == ST_LOAD;
   assign rsp_ch.valid           = state_ff == ST_OUT;
   assign rsp_ch.served_cylinder = cur_cyl;
   assign rsp_ch.order_position  = POS_W'(k_ff);
   assign rsp_ch.last_result     = final_result;
   assign rsp_ch.total_travel    = final_result ? travel : '0;
   assign rsp_ch.overflowed      = ovf_ff;

   // Loading and emitting never overlap.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("request and result channels active together");

   // The fill count never passes the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_REQUESTS))
      else $error("stored request count beyond capacity");

   // Every emitted position lies inside the batch.
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> (k_ff < n_ff))
      else $error("result position beyond batch size");

   // After the final beat the store is empty and the overflow mark is gone.
   a_batch_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_ch.last_result) |=> (count_ff == '0 && !ovf_ff && req_ch.ready))
      else $error("batch state not cleared after final result");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the C-SCAN disk request ordering block.
// Drives request batches and register settings, predicts the service order and travel,
// and checks every result beat. Depends on csd_pkg, csd_req_if, csd_rsp_if and the RTL.
module tb_top import csd_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_PERCENT    = 33;
   localparam int RANDOM_ITEMS    = 150;
   // After the last expected beat the block is given this long to settle into loading.
   localparam int DRAIN_CYCLES    = CSD_MAX_REQUESTS + 16;
   localparam int HOLD_OFF_CYCLES = 1500;
   localparam int TRAVEL_MAX      = (1 << TRAVEL_W) - 1;

   // One expected result beat.
   typedef struct {
      logic [CYL_W-1:0]    cylinder;
      logic [POS_W-1:0]    position;
      logic                closing;
      logic [TRAVEL_W-1:0] travel;
      logic                dropped;
   } served_beat_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   csd_req_if req_ch ();
   csd_rsp_if rsp_ch ();

   cscan_disk_request_order u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor state: the batch being collected and the register copies.
   logic [CYL_W-1:0]      batch_store [CSD_MAX_REQUESTS];
   int                    batch_count;
   logic                  batch_dropped;
   logic [CYL_W-1:0]      head_start;
   logic [CSR_DATA_W-1:0] disk_size;
   logic                  sweeping_up;

   // Service order still owed by the block, oldest first.
   served_beat_type pending_service [$];

   int error_count;
   int requests_sent;
   int results_checked;
   int batches_closed;
   int down_batches;
   int overflow_batches;

   // Both sides idle at random while this is set.
   bit idle_on;
   // When nonzero, the receiver holds ready low and counts this value down.
   int hold_cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard limit on the run: far beyond the slowest legal schedule.
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic int unsigned head_distance(int unsigned a, int unsigned b);
      return (a > b) ? a - b : b - a;
   endfunction

   // Sort the batch, split it around the start cylinder and walk it in C-SCAN
   // order, queueing one expected beat per stored request. The run to the disk
   // end and the full return jump always count toward the travel.
   function automatic void plan_service_order();
      logic [CYL_W-1:0] sorted [CSD_MAX_REQUESTS];
      logic [CYL_W-1:0] order [$];
      logic [CYL_W-1:0] v;
      int               n;
      int               split;
      int               j;
      int unsigned      top_cyl;
      int unsigned      head;
      int unsigned      travel;
      served_beat_type  beat;

      n = batch_count;
      for (int i = 0; i < n; i++) begin
         v = batch_store[i];
         j = i;
         while (j > 0 && sorted[j-1] > v) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = v;
      end

      // Requests at the start cylinder belong to the lower group.
      split = 0;
      while (split < n && sorted[split] <= head_start) split++;

      // Highest cylinder, saturated into the cylinder range.
      if (disk_size == 0) begin
         top_cyl = 0;
      end else if (disk_size - 1 > 65535) begin
         top_cyl = 65535;
      end else begin
         top_cyl = disk_size - 1;
      end

      head   = head_start;
      travel = 0;
      if (sweeping_up) begin
         for (int i = split; i < n; i++) begin
            travel += head_distance(head, sorted[i]);
            head = sorted[i];
            order.push_back(sorted[i]);
         end
         travel += head_distance(head, top_cyl) + top_cyl;
         head = 0;
         for (int i = 0; i < split; i++) begin
            travel += head_distance(head, sorted[i]);
            head = sorted[i];
            order.push_back(sorted[i]);
         end
      end else begin
         for (int i = split; i > 0; i--) begin
            travel += head_distance(head, sorted[i-1]);
            head = sorted[i-1];
            order.push_back(sorted[i-1]);
         end
         travel += head + top_cyl;
         head = top_cyl;
         for (int i = n; i > split; i--) begin
            travel += head_distance(head, sorted[i-1]);
            head = sorted[i-1];
            order.push_back(sorted[i-1]);
         end
      end
      if (travel > TRAVEL_MAX) travel = TRAVEL_MAX;

      for (int k = 0; k < n; k++) begin
         beat.cylinder = order[k];
         beat.position = k[POS_W-1:0];
         beat.closing  = (k == n - 1);
         beat.travel   = (k == n - 1) ? travel[TRAVEL_W-1:0] : '0;
         beat.dropped  = batch_dropped;
         pending_service.push_back(beat);
      end

      batches_closed++;
      if (!sweeping_up) down_batches++;
      if (batch_dropped) overflow_batches++;
      batch_count   = 0;
      batch_dropped = 1'b0;
   endfunction

   // Offer one request beat and return once it has been accepted. Valid is left
   // high afterward so that the next beat can follow without a gap; it is only
   // lowered by an idle cycle or by wait_drained.
   task automatic send_request(input logic [CYL_W-1:0] cylinder, input logic closing);
      while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid            <= 1'b1;
      req_ch.request_cylinder <= cylinder;
      req_ch.last_request     <= closing;
      do @(posedge clock); while (!req_ch.ready);
      requests_sent++;

      // The beat is in: mirror the block's store and overflow behavior.
      if (batch_count < CSD_MAX_REQUESTS) begin
         batch_store[batch_count] = cylinder;
         batch_count++;
      end else begin
         batch_dropped = 1'b1;
      end
      if (closing) plan_service_order();
   endtask

   // Stop offering, wait for every owed result, then give the block time to
   // finish its last pass before anything reconfigures it.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_service.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write one register. The enable stays high so writes can run back to back;
   // set_config lowers it after the last one.
   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      case (index)
         CSR_START_POSITION: head_start  = data[CYL_W-1:0];
         CSR_DISK_CYLINDERS: disk_size   = data;
         CSR_SWEEP_UP:       sweeping_up = data[0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] start_cyl,
                             input logic [CSR_DATA_W-1:0] cylinders,
                             input logic                  up);
      write_register(CSR_START_POSITION, start_cyl);
      write_register(CSR_DISK_CYLINDERS, cylinders);
      write_register(CSR_SWEEP_UP, {{(CSR_DATA_W-1){1'b0}}, up});
      csr_we <= 1'b0;
   endtask

   // Cylinder picker for random batches. Mode 0 spreads over the whole range,
   // mode 1 clusters around the start cylinder so the split point moves a lot,
   // mode 2 hits the edges, the start and its neighbours, mode 3 stays on the disk.
   function automatic logic [CYL_W-1:0] pick_cylinder(input int mode);
      int near;
      case (mode)
         1: begin
            near = int'(head_start) + int'($urandom_range(0, 60)) - 30;
            if (near < 0) near = 0;
            if (near > 65535) near = 65535;
            return near[CYL_W-1:0];
         end
         2: begin
            case ($urandom_range(0, 4))
               0: return '0;
               1: return '1;
               2: return head_start;
               3: return head_start + 1'b1;
               default: return head_start - 1'b1;
            endcase
         end
         3: begin
            if (disk_size < 2) return '0;
            if (disk_size > 65536) return CYL_W'($urandom_range(0, 65535));
            return CYL_W'($urandom_range(0, disk_size - 1));
         end
         default: return CYL_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         error_count++;
         $error("%s: expected %0d, actual %0d", name, want, got);
      end
   endfunction

   // Receiver: checks each accepted result beat against the oldest expectation
   // and drives ready, with random idling and the long hold-off when asked.
   initial begin
      served_beat_type want;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            results_checked++;
            if (pending_service.size() == 0) begin
               error_count++;
               $error("result beat with nothing expected: served_cylinder %0d",
                      rsp_ch.served_cylinder);
            end else begin
               want = pending_service.pop_front();
               check_field("served_cylinder", want.cylinder, rsp_ch.served_cylinder);
               check_field("order_position", want.position, rsp_ch.order_position);
               check_field("last_result", want.closing, rsp_ch.last_result);
               check_field("total_travel", want.travel, rsp_ch.total_travel);
               check_field("overflowed", want.dropped, rsp_ch.overflowed);
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PERCENT);
         end
      end
   end

   // Default registers: start 0, full disk, sweeping up. Cylinder 0 equals the
   // start and so lands in the wrapped group; a duplicate must come out twice.
   task automatic test_reset_defaults();
      send_request(16'd0, 1'b0);
      send_request(16'd65535, 1'b0);
      send_request(16'd100, 1'b0);
      send_request(16'd100, 1'b0);
      send_request(16'd32768, 1'b1);
      wait_drained();
   endtask

   // A mixed batch on both sides of the start, swept up and then down. The
   // request on the start cylinder goes with the lower group.
   task automatic test_sweep_directions();
      set_config(17'd1000, 17'd5000, 1'b1);
      send_request(16'd4999, 1'b0);
      send_request(16'd1000, 1'b0);
      send_request(16'd1500, 1'b0);
      send_request(16'd20, 1'b0);
      send_request(16'd3000, 1'b1);
      wait_drained();
      set_config(17'd1000, 17'd5000, 1'b0);
      send_request(16'd4999, 1'b0);
      send_request(16'd1000, 1'b0);
      send_request(16'd999, 1'b0);
      send_request(16'd1500, 1'b0);
      send_request(16'd20, 1'b0);
      send_request(16'd3000, 1'b1);
      wait_drained();
   endtask

   // One side of the start is empty: the sweep still runs to the disk end and
   // takes the return jump before serving the other side.
   task automatic test_empty_groups();
      set_config(17'd65535, 17'd65536, 1'b1);
      send_request(16'd7, 1'b0);
      send_request(16'd65535, 1'b1);
      wait_drained();
      set_config(17'd0, 17'd65536, 1'b0);
      send_request(16'd5, 1'b0);
      send_request(16'd9, 1'b1);
      wait_drained();
   endtask

   // Disk sizes at and past the extremes, with the start and requests lying
   // beyond the last cylinder.
   task automatic test_odd_disk_sizes();
      set_config(17'd10, 17'd0, 1'b1);
      send_request(16'd3, 1'b0);
      send_request(16'd20, 1'b1);
      wait_drained();
      set_config(17'd300, 17'd200, 1'b0);
      send_request(16'd250, 1'b0);
      send_request(16'd40, 1'b0);
      send_request(16'd199, 1'b1);
      wait_drained();
      set_config(17'd5, 17'd1, 1'b0);
      send_request(16'd65535, 1'b1);
      wait_drained();
      set_config(17'd5, 17'd131071, 1'b1);
      send_request(16'd65535, 1'b1);
      wait_drained();
   endtask

   // More requests than the store holds: the extras, the closing one included,
   // are dropped and every result of the batch carries the overflow mark.
   task automatic test_store_overflow();
      set_config(CSR_DATA_W'($urandom_range(0, 65535)), 17'd65536,
                 1'($urandom_range(0, 1)));
      for (int i = 0; i < CSD_MAX_REQUESTS + 6; i++)
         send_request(pick_cylinder($urandom_range(0, 3)), i == CSD_MAX_REQUESTS + 5);
      wait_drained();
   endtask

   // The receiver stops for a long stretch while the sender keeps offering
   // batches, so the block must stall its input while results back up.
   task automatic test_back_pressure();
      set_config(17'd30000, 17'd65536, 1'b1);
      hold_cycles = HOLD_OFF_CYCLES;
      for (int b = 0; b < 3; b++)
         for (int i = 0; i < 8; i++)
            send_request(pick_cylinder($urandom_range(0, 2)), i == 7);
      wait_drained();
   endtask

   // Random batches, mostly short with a few near-full, full or overfull ones. Registers
   // change every few batches once the block has gone quiet. The middle third
   // runs with no idling on either side.
   task automatic test_random_batches();
      int                    sent;
      int                    batch_no;
      int                    size;
      int                    mode;
      logic [CSR_DATA_W-1:0] start_v;
      logic [CSR_DATA_W-1:0] cyl_v;
      sent     = 0;
      batch_no = 0;
      while (sent < RANDOM_ITEMS) begin
         if (batch_no % 4 == 0) begin
            wait_drained();
            case ($urandom_range(0, 3))
               0:       start_v = 17'd0;
               1:       start_v = 17'd65535;
               default: start_v = CSR_DATA_W'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 5))
               0:       cyl_v = 17'd0;
               1:       cyl_v = 17'd1;
               2:       cyl_v = 17'd65536;
               3:       cyl_v = 17'd131071;
               4:       cyl_v = CSR_DATA_W'($urandom_range(2, 1000));
               default: cyl_v = CSR_DATA_W'($urandom_range(0, 131071));
            endcase
            set_config(start_v, cyl_v, 1'($urandom_range(0, 1)));
         end
         idle_on = !(sent >= RANDOM_ITEMS / 3 && sent < 2 * RANDOM_ITEMS / 3);
         case ($urandom_range(0, 99)) inside
            [0:74]:  size = $urandom_range(1, 8);
            [75:94]: size = $urandom_range(9, 30);
            default: size = $urandom_range(CSD_MAX_REQUESTS - 4, CSD_MAX_REQUESTS + 4);
         endcase
         mode = $urandom_range(0, 3);
         for (int i = 0; i < size; i++)
            send_request(pick_cylinder(mode), i == size - 1);
         sent += size;
         batch_no++;
      end
      idle_on = 1'b1;
      wait_drained();
   endtask

   initial begin
      req_ch.valid            <= 1'b0;
      req_ch.request_cylinder <= '0;
      req_ch.last_request     <= 1'b0;
      csr_we                  <= 1'b0;
      csr_index               <= CSR_START_POSITION;
      csr_wdata               <= '0;
      reset                   <= 1'b1;
      idle_on          = 1'b1;
      hold_cycles      = 0;
      error_count      = 0;
      requests_sent    = 0;
      results_checked  = 0;
      batches_closed   = 0;
      down_batches     = 0;
      overflow_batches = 0;
      batch_count      = 0;
      batch_dropped    = 1'b0;
      head_start       = START_RESET;
      disk_size        = CYLINDERS_RESET;
      sweeping_up      = SWEEP_UP_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_sweep_directions();
      test_empty_groups();
      test_odd_disk_sizes();
      test_store_overflow();
      test_back_pressure();
      test_random_batches();

      $display("Run covered %0d request beats in %0d batches (%0d swept down, %0d overfull),",
               requests_sent, batches_closed, down_batches, overflow_batches);
      $display("with %0d result beats checked against the predicted service order.",
               results_checked);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
